@@ rtl/core/mppi_pkg.sv @@
// Shared types and constants for the prime-modulus power/inverse unit.
package mppi_pkg;

    localparam int VAL_W = 30;
    localparam int EXP_W = 30;

    typedef logic [VAL_W-1:0] t_residue;
    typedef logic [EXP_W-1:0] t_exponent;

    localparam t_residue    MOD_P        = 30'd1000000007;
    localparam logic [31:0] MOD_2P       = 32'd2000000014;
    localparam t_exponent   INV_EXPONENT = 30'd1000000005;
    // floor(2^60 / MOD_P), Barrett reciprocal
    localparam logic [30:0] BARRETT_MU   = 31'd1152921496;

    localparam logic CMD_POWER   = 1'b0;
    localparam logic CMD_INVERSE = 1'b1;

    typedef struct packed {
        logic      command;
        t_residue  base_value;
        t_exponent exponent;
    } t_in_item;

    typedef struct packed {
        t_residue residue_out;
    } t_out_item;

    typedef struct packed {
        logic     start;
        t_residue a;
        t_residue b;
    } t_mm_req;

    typedef struct packed {
        logic     done;
        t_residue result;
    } t_mm_rsp;

endpackage

@@ rtl/core/mppi_stream_if.sv @@
// Valid/ready stream channel carrying one payload per transaction.
interface mppi_stream_if #(
    parameter type T_DATA = logic
);
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/mppi_mulmod.sv @@
// Multi-cycle modular multiplier: one shared 31x31 multiplier, Barrett reduction.
module mppi_mulmod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mppi_pkg::t_mm_req i_req,
    output mppi_pkg::t_mm_rsp o_rsp
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_PROD = 3'd1;
    localparam logic [2:0] PH_QUOT = 3'd2;
    localparam logic [2:0] PH_QP   = 3'd3;
    localparam logic [2:0] PH_FIX  = 3'd4;

    logic [2:0]         r_phase;
    logic [2:0]         n_phase;
    mppi_pkg::t_residue r_a;
    mppi_pkg::t_residue r_b;
    logic [59:0]        r_x;
    mppi_pkg::t_residue r_q;
    logic [31:0]        r_r;
    mppi_pkg::t_residue r_res;
    logic               r_done;

    logic [30:0]        w_op_a;
    logic [30:0]        w_op_b;
    logic [61:0]        w_prod;
    logic [31:0]        w_r_m1;
    logic [31:0]        w_r_m2;
    mppi_pkg::t_residue w_fixed;

    // the one multiplier, operands chosen by phase
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        unique case (r_phase)
            PH_PROD: begin
                w_op_a = {1'b0, r_a};
                w_op_b = {1'b0, r_b};
            end
            PH_QUOT: begin
                w_op_a = r_x[59:29];
                w_op_b = mppi_pkg::BARRETT_MU;
            end
            PH_QP: begin
                w_op_a = {1'b0, r_q};
                w_op_b = {1'b0, mppi_pkg::MOD_P};
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    assign w_prod = 62'(w_op_a) * 62'(w_op_b);

    // remainder estimate is below 3p, so at most two subtractions
    assign w_r_m1 = r_r - 32'(mppi_pkg::MOD_P);
    assign w_r_m2 = r_r - mppi_pkg::MOD_2P;

    always_comb begin
        priority if (r_r >= mppi_pkg::MOD_2P) begin
            w_fixed = w_r_m2[29:0];
        end else if (r_r >= 32'(mppi_pkg::MOD_P)) begin
            w_fixed = w_r_m1[29:0];
        end else begin
            w_fixed = r_r[29:0];
        end
    end

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: if (i_req.start) n_phase = PH_PROD;
            PH_PROD: n_phase = PH_QUOT;
            PH_QUOT: n_phase = PH_QP;
            PH_QP:   n_phase = PH_FIX;
            PH_FIX:  n_phase = PH_IDLE;
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == PH_FIX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == PH_IDLE && i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end
        if (r_phase == PH_PROD) begin
            r_x <= w_prod[59:0];
        end
        if (r_phase == PH_QUOT) begin
            r_q <= w_prod[60:31];
        end
        if (r_phase == PH_QP) begin
            r_r <= r_x[31:0] - w_prod[31:0];
        end
        if (r_phase == PH_FIX) begin
            r_res <= w_fixed;
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule

@@ rtl/core/mod_prime_power_inverse_top.sv @@
// Top level: modular power / Fermat inverse modulo 1000000007.
// Computes base_value^exponent mod 1000000007 by right-to-left square-and-multiply,
// or the modular inverse (exponent 1000000005) when command is 1; zero inverts to
// zero and a zero exponent gives one. One shared modular multiplier does all the
// work, each multiplication going through product, Barrett quotient, quotient times
// modulus, final correction and handoff, plus a sequencer step per exponent bit.
// Completion of an item is delayed only while the previous result has not yet
// been taken. One item is in flight at a time; the input is ready whenever the
// sequencer is idle, and a finished result sits in an output register so the
// next transaction can be accepted while it waits to be taken.
module mod_prime_power_inverse_top #(
    parameter int EXP_BITS = 30
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mppi_stream_if.sink    i_in,
    mppi_stream_if.source  o_out
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_STEP    = 2'd1;
    localparam logic [1:0] ST_MUL_ACC = 2'd2;
    localparam logic [1:0] ST_MUL_SQ  = 2'd3;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    mppi_pkg::t_residue  r_base;
    mppi_pkg::t_residue  r_acc;
    mppi_pkg::t_exponent r_exp;
    logic                r_out_valid;
    mppi_pkg::t_residue  r_out_data;

    mppi_pkg::t_exponent w_exp_mask;
    mppi_pkg::t_exponent w_exp_load;
    mppi_pkg::t_residue  w_base_red;
    logic                w_out_free;
    logic                w_exp_last;
    logic                w_finish;
    mppi_pkg::t_mm_req   w_req;
    mppi_pkg::t_mm_rsp   w_rsp;

    always_comb begin
        for (int i = 0; i < mppi_pkg::EXP_W; i++) begin
            w_exp_mask[i] = (i < EXP_BITS);
        end
    end

    assign w_base_red = (i_in.data.base_value >= mppi_pkg::MOD_P)
                      ? i_in.data.base_value - mppi_pkg::MOD_P
                      : i_in.data.base_value;
    assign w_exp_load = (i_in.data.command == mppi_pkg::CMD_INVERSE)
                      ? mppi_pkg::INV_EXPONENT
                      : (i_in.data.exponent & w_exp_mask);

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_exp_last = (r_exp[mppi_pkg::EXP_W-1:1] == '0);
    assign w_finish   = (r_state == ST_STEP) && (r_exp == '0) && w_out_free;

    always_comb begin
        n_state     = r_state;
        w_req.start = 1'b0;
        w_req.a     = r_acc;
        w_req.b     = r_base;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) n_state = ST_STEP;
            end
            ST_STEP: begin
                if (r_exp == '0) begin
                    if (w_out_free) n_state = ST_IDLE;
                end else if (r_exp[0]) begin
                    w_req.start = 1'b1;
                    n_state     = ST_MUL_ACC;
                end else begin
                    w_req.start = 1'b1;
                    w_req.a     = r_base;
                    n_state     = ST_MUL_SQ;
                end
            end
            ST_MUL_ACC: begin
                if (w_rsp.done) begin
                    // no squaring needed after the top bit
                    if (w_exp_last) begin
                        n_state = ST_STEP;
                    end else begin
                        w_req.start = 1'b1;
                        w_req.a     = r_base;
                        n_state     = ST_MUL_SQ;
                    end
                end
            end
            ST_MUL_SQ: begin
                if (w_rsp.done) n_state = ST_STEP;
            end
        endcase
    end

    mppi_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in.valid) begin
            r_base <= w_base_red;
            r_acc  <= mppi_pkg::t_residue'(1);
            r_exp  <= w_exp_load;
        end
        if (r_state == ST_MUL_ACC && w_rsp.done) begin
            r_acc <= w_rsp.result;
            if (w_exp_last) r_exp <= r_exp >> 1;
        end
        if (r_state == ST_MUL_SQ && w_rsp.done) begin
            r_base <= w_rsp.result;
            r_exp  <= r_exp >> 1;
        end
        if (w_finish) begin
            r_out_data <= r_acc;
        end
    end

    assign i_in.ready             = (r_state == ST_IDLE);
    assign o_out.valid            = r_out_valid;
    assign o_out.data.residue_out = r_out_data;

endmodule
